FILE: hdl/gamepad_state_and_keystroke_unit_assert.svh
// Assertion macros for the gamepad state and keystroke unit.
`ifndef GAMEPAD_STATE_AND_KEYSTROKE_UNIT_ASSERT_SVH
`define GAMEPAD_STATE_AND_KEYSTROKE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// cons must hold in the same cycle as ante
`define GPSK_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define GPSK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GPSK_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define GPSK_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hdl/gpsk_pkg.sv
// Shared types, codes and helper functions of the gamepad state and keystroke unit.
package gpsk_pkg;

  localparam int KEYS  = 24;
  localparam int KEY_W = 5;
  localparam int LVL_W = 16;
  localparam int NUM_BUTTONS = 14;

  // actions
  localparam logic [2:0] ACT_KEY    = 3'd0;
  localparam logic [2:0] ACT_STATE  = 3'd1;
  localparam logic [2:0] ACT_STROKE = 3'd2;
  localparam logic [2:0] ACT_ATTACH = 3'd3;
  localparam logic [2:0] ACT_DETACH = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  // key indices
  localparam logic [KEY_W-1:0] KEY_FIRST = 5'd0;
  localparam logic [KEY_W-1:0] KEY_LTRIG = 5'd14;
  localparam logic [KEY_W-1:0] KEY_RTRIG = 5'd15;
  localparam logic [KEY_W-1:0] KEY_LAST  = 5'd23;

  localparam logic [15:0] BUTTON_MAP [NUM_BUTTONS] = '{
    16'h0004, 16'h0001, 16'h0008, 16'h0002, 16'h1000, 16'h2000, 16'h4000,
    16'h8000, 16'h0020, 16'h0010, 16'h0100, 16'h0200, 16'h0040, 16'h0080
  };

  localparam logic [7:0] TRIG_FULL = 8'hFF;

  // result beat, first field in the highest bits
  typedef struct packed {
    logic [2:0]        stroke_flags;
    logic [KEY_W-1:0]  stroke_key;
    logic signed [15:0] right_y;
    logic signed [15:0] right_x;
    logic signed [15:0] left_y;
    logic signed [15:0] left_x;
    logic [7:0]        right_trig;
    logic [7:0]        left_trig;
    logic [15:0]       button_bits;
    logic [31:0]       packet_count;
  } result_t;

  // one key level handed to the accumulator
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [LVL_W-1:0] level;
  } lvl_step_t;

  typedef struct packed {
    logic [7:0]         left_trig;
    logic [7:0]         right_trig;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
  } lvl_sum_t;

  function automatic logic [15:0] pack_buttons(input logic [NUM_BUTTONS-1:0] p);
    logic [15:0] b;
    b = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (p[i]) b = b | BUTTON_MAP[i];
    end
    return b;
  endfunction

  // slot * KEYS as shifts
  function automatic logic [7:0] slot_base(input logic [2:0] s);
    return 8'({s, 4'b0000}) + 8'({s, 3'b000});
  endfunction

endpackage

FILE: hdl/gpsk_level_acc.sv
// Trigger and thumb-axis accumulator, fed one pressed key level per cycle.
module gpsk_level_acc (
  input  logic                 clk,
  input  logic                 clr,
  input  gpsk_pkg::lvl_step_t  step,
  output gpsk_pkg::lvl_sum_t   sum
);

  logic [7:0]  left_trig;
  logic [7:0]  right_trig;
  logic [15:0] axis [4];
  logic [1:0]  axis_sel;
  logic [7:0]  trig;

  // keys 16..23 run lx, ly, lx, ly, rx, ry, rx, ry
  assign axis_sel = {step.key[2], step.key[0]};

  // negative or above 255 saturates
  assign trig = (step.level[15] || (step.level[14:8] != '0)) ? gpsk_pkg::TRIG_FULL
                                                            : step.level[7:0];

  always_ff @(posedge clk) begin
    if (clr) begin
      left_trig  <= '0;
      right_trig <= '0;
      for (int a = 0; a < 4; a++) axis[a] <= '0;
    end else if (step.vld) begin
      case (step.key)
        gpsk_pkg::KEY_LTRIG: left_trig  <= trig;
        gpsk_pkg::KEY_RTRIG: right_trig <= trig;
        default: begin
          if (step.key > gpsk_pkg::KEY_RTRIG) axis[axis_sel] <= step.level;
        end
      endcase
    end
  end

  assign sum.left_trig  = left_trig;
  assign sum.right_trig = right_trig;
  assign sum.left_x     = axis[0];
  assign sum.left_y     = axis[1];
  assign sum.right_x    = axis[2];
  assign sum.right_y    = axis[3];

endmodule

FILE: hdl/gamepad_state_and_keystroke_unit.sv
// Top level of the gamepad state and keystroke unit.
//
// Emulated gamepads, one per slot below DEVICES. Key events, attach and detach produce no
// result beat. For a state poll the sequencer walks the ten analog keys (triggers and thumb
// axes) through the key level memory, one key per cycle, feeding one shared saturate/select
// unit, then passes S_DRAIN and S_DONE, where the result is loaded. A keystroke poll scans
// the pending flags one key per cycle from the lowest key upward and stops at the first
// pending key. Polls on absent slots go straight to S_DONE. The input is ready again in the
// cycle after a result is loaded. The result sits in an output register, so the next item is
// taken while it waits; the block stalls only when a new result is ready and the previous one
// has not been taken.
module gamepad_state_and_keystroke_unit #(
  parameter int DEVICES = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot[2:0], key_number[7:3], key_down[8], key_value[24:9], zeros above
  input  logic [31:0]  s_tdata,
  // action[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // packet_count[31:0], button_bits[47:32], left_trig[55:48], right_trig[63:56],
  // left_x[79:64], left_y[95:80], right_x[111:96], right_y[127:112],
  // stroke_key[132:128], stroke_flags[135:133]
  output logic [$bits(gpsk_pkg::result_t)-1:0] m_tdata,
  // status[1:0]
  output logic [1:0]   m_tuser
);

  localparam int SLOT_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int DEPTH  = DEVICES * gpsk_pkg::KEYS;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  logic [2:0]                     in_action;
  logic [2:0]                     in_slot;
  logic [gpsk_pkg::KEY_W-1:0]     in_key;
  logic                           in_down;
  logic [gpsk_pkg::LVL_W-1:0]     in_level;
  logic                           accept;
  logic                           slot_in_range;
  logic                           slot_ok;
  logic                           key_ok;
  logic [SLOT_W-1:0]              sidx;
  logic [ADDR_W-1:0]              waddr;
  logic                           lvl_we;

  logic                           present      [DEVICES];
  logic [gpsk_pkg::KEYS-1:0]      pressed      [DEVICES];
  logic [gpsk_pkg::KEYS-1:0]      prior        [DEVICES];
  logic [gpsk_pkg::KEYS-1:0]      pending      [DEVICES];
  logic [31:0]                    poll_cnt     [DEVICES];
  logic [gpsk_pkg::LVL_W-1:0]     lvl_mem      [DEPTH];

  logic [SLOT_W-1:0]              cur_sidx;
  logic [ADDR_W-1:0]              cur_base;
  logic [gpsk_pkg::KEY_W-1:0]     wkey;
  logic [gpsk_pkg::KEY_W-1:0]     rd_key;
  logic                           rd_vld;
  logic [gpsk_pkg::LVL_W-1:0]     rd_lvl;
  logic                           scan_hit;
  logic                           cur_down;
  logic                           pre_down;
  logic [2:0]                     flags;
  logic                           out_free;

  gpsk_pkg::result_t              res;
  gpsk_pkg::result_t              res_load;
  logic [1:0]                     res_status;
  gpsk_pkg::result_t              out_word;
  gpsk_pkg::result_t              m_res;
  gpsk_pkg::lvl_step_t            acc_step;
  gpsk_pkg::lvl_sum_t             acc_sum;

  assign in_action = s_tuser;
  assign in_slot   = s_tdata[2:0];
  assign in_key    = s_tdata[7:3];
  assign in_down   = s_tdata[8];
  assign in_level  = s_tdata[24:9];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign slot_in_range = int'(in_slot) < DEVICES;
  assign sidx          = in_slot[SLOT_W-1:0];
  assign slot_ok       = slot_in_range && present[sidx];
  assign key_ok        = in_key <= gpsk_pkg::KEY_LAST;
  assign waddr         = ADDR_W'(gpsk_pkg::slot_base(in_slot) + 8'(in_key));
  assign lvl_we        = accept && (in_action == gpsk_pkg::ACT_KEY) && slot_ok && key_ok;

  assign scan_hit = pending[cur_sidx][wkey];
  assign cur_down = pressed[cur_sidx][wkey];
  assign pre_down = prior[cur_sidx][wkey];
  assign flags    = {cur_down == pre_down, !cur_down, cur_down};

  // key level memory
  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[waddr] <= in_level;
    rd_lvl <= lvl_mem[cur_base + ADDR_W'(wkey)];
  end

  assign acc_step.vld   = rd_vld;
  assign acc_step.key   = rd_key;
  assign acc_step.level = rd_lvl;

  gpsk_level_acc u_acc (
    .clk  (clk),
    .clr  (accept),
    .step (acc_step),
    .sum  (acc_sum)
  );

  // control and per-slot key state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      rd_vld   <= 1'b0;
      wkey     <= gpsk_pkg::KEY_FIRST;
      for (int d = 0; d < DEVICES; d++) begin
        present[d]  <= 1'b0;
        pressed[d]  <= '0;
        prior[d]    <= '0;
        pending[d]  <= '0;
        poll_cnt[d] <= '0;
      end
    end else begin
      // only pressed keys reach the accumulator
      rd_vld <= (state == S_WALK) && cur_down;
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_action)
              gpsk_pkg::ACT_KEY: begin
                if (slot_ok && key_ok) begin
                  prior[sidx][in_key]   <= pressed[sidx][in_key];
                  pressed[sidx][in_key] <= in_down;
                  if (pressed[sidx][in_key] != in_down) pending[sidx][in_key] <= 1'b1;
                end
              end
              gpsk_pkg::ACT_STATE: begin
                if (slot_ok) begin
                  poll_cnt[sidx] <= poll_cnt[sidx] + 32'd1;
                  wkey           <= gpsk_pkg::KEY_LTRIG;
                  state          <= S_WALK;
                end else begin
                  state <= S_DONE;
                end
              end
              gpsk_pkg::ACT_STROKE: begin
                if (slot_ok) begin
                  wkey  <= gpsk_pkg::KEY_FIRST;
                  state <= S_SCAN;
                end else begin
                  state <= S_DONE;
                end
              end
              gpsk_pkg::ACT_ATTACH: begin
                if (slot_in_range) begin
                  present[sidx] <= 1'b1;
                  pressed[sidx] <= '0;
                  prior[sidx]   <= '0;
                  pending[sidx] <= '0;
                end
              end
              gpsk_pkg::ACT_DETACH: begin
                if (slot_ok) begin
                  present[sidx] <= 1'b0;
                  pressed[sidx] <= '0;
                  prior[sidx]   <= '0;
                  pending[sidx] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (wkey == gpsk_pkg::KEY_LAST) state <= S_DRAIN;
          else wkey <= wkey + 5'd1;
        end
        S_DRAIN: state <= S_DONE;
        S_SCAN: begin
          if (scan_hit) begin
            pending[cur_sidx][wkey] <= 1'b0;
            state <= S_DONE;
          end else if (wkey == gpsk_pkg::KEY_LAST) begin
            state <= S_DONE;
          end else begin
            wkey <= wkey + 5'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload captured when an item is taken
  always_comb begin
    res_load = '0;
    if (in_action == gpsk_pkg::ACT_STATE && slot_ok) begin
      res_load.packet_count = poll_cnt[sidx] + 32'd1;
      res_load.button_bits  = gpsk_pkg::pack_buttons(pressed[sidx][gpsk_pkg::NUM_BUTTONS-1:0]);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    rd_key <= wkey;
    if (accept) begin
      cur_sidx   <= sidx;
      cur_base   <= ADDR_W'(gpsk_pkg::slot_base(in_slot));
      res_status <= slot_ok ? gpsk_pkg::ST_OK : gpsk_pkg::ST_ABSENT;
      res        <= res_load;
    end
    if (state == S_SCAN) begin
      if (scan_hit) begin
        {res.stroke_flags, res.stroke_key} <= {flags, wkey};
      end else if (wkey == gpsk_pkg::KEY_LAST) begin
        res_status <= gpsk_pkg::ST_EMPTY;
      end
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= out_word;
      m_tuser <= res_status;
    end
  end

  // accumulator is cleared on every accepted item, so it reads zero outside state polls
  always_comb begin
    out_word            = res;
    out_word.left_trig  = acc_sum.left_trig;
    out_word.right_trig = acc_sum.right_trig;
    out_word.left_x     = acc_sum.left_x;
    out_word.left_y     = acc_sum.left_y;
    out_word.right_x    = acc_sum.right_x;
    out_word.right_y    = acc_sum.right_y;
  end

  assign m_res = m_tdata;

`include "gamepad_state_and_keystroke_unit_assert.svh"

  `GPSK_ASSERT_IMP(a_walk_range, clk, rst, state == S_WALK, wkey >= gpsk_pkg::KEY_LTRIG && wkey <= gpsk_pkg::KEY_LAST, "walk left the analog keys")
  `GPSK_ASSERT_NEXT(a_poll_busy, clk, rst, accept && slot_ok && (in_action == gpsk_pkg::ACT_STATE || in_action == gpsk_pkg::ACT_STROKE), state == S_WALK || state == S_SCAN, "poll on present slot did not start")
  `GPSK_ASSERT_NEXT(a_done_loads, clk, rst, state == S_DONE && out_free, m_tvalid && state == S_IDLE, "finished result not presented")
  `GPSK_ASSERT_IMP(a_stroke_flags, clk, rst, m_tvalid, !(m_res.stroke_flags[0] && m_res.stroke_flags[1]), "keystroke both down and up")

endmodule
